// ===== rtl/core/dpid_pkg.sv =====
// Shared types, widths and helper functions for the discrete PID controller.
package dpid_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int OUT_WIDTH   = 32;
    localparam int GAIN_W      = 32;
    localparam int INTEG_W     = 32;
    localparam int ERR_W       = DATA_WIDTH + 1;
    localparam int SUM_W       = DATA_WIDTH + 2;
    localparam int OPD_W       = (SUM_W < 32) ? SUM_W : 32;
    localparam int PROD_W      = OPD_W + GAIN_W;
    localparam int CLAMP_W     = SUM_W + 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic signed [CLAMP_W-1:0] OPD_LIM  = CLAMP_W'(64'sd1073741824);
    localparam logic signed [CLAMP_W-1:0] OPD_NLIM = -OPD_LIM;

    typedef enum logic [1:0] {
        MODE_PID = 2'd0,
        MODE_P   = 2'd1,
        MODE_PI  = 2'd2,
        MODE_PD  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 2'd0,
        REG_GAIN_P      = 2'd1,
        REG_GAIN_I_HALF = 2'd2,
        REG_GAIN_D      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_STEP  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i_half;
        logic signed [GAIN_W-1:0] gain_d;
    } cfg_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic                     clear;
        logic signed [OPD_W-1:0] err;
        logic signed [OPD_W-1:0] err_sum;
        logic signed [OPD_W-1:0] err_diff;
    } item_t;

    // Limit a multiplier operand to +-2^30 (only bites at very wide data).
    function automatic logic signed [OPD_W-1:0] clamp_opd(input logic signed [SUM_W-1:0] x);
        logic signed [CLAMP_W-1:0] wx;
        logic signed [OPD_W-1:0]   r;
        wx = CLAMP_W'(x);
        if (wx > OPD_LIM) begin
            r = OPD_LIM[OPD_W-1:0];
        end else if (wx < OPD_NLIM) begin
            r = OPD_NLIM[OPD_W-1:0];
        end else begin
            r = x[OPD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic use_integral(input mode_t m);
        return (m == MODE_PID) || (m == MODE_PI);
    endfunction

    function automatic logic use_derivative(input mode_t m);
        return (m == MODE_PID) || (m == MODE_PD);
    endfunction

endpackage

// ===== rtl/core/dpid_front.sv =====
// Front end: accepts input words, forms error terms and tracks the previous error.
module dpid_front
    import dpid_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [DATA_WIDTH-1:0] measurement,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    input  logic                         q_full,
    output logic                         q_push,
    output item_t                        q_data
);

    logic signed [ERR_W-1:0] prev_error_reg;
    logic signed [ERR_W-1:0] prev_error_next;
    logic signed [SUM_W-1:0] err;
    logic signed [SUM_W-1:0] err_sum;
    logic signed [SUM_W-1:0] err_diff;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        err      = SUM_W'(setpoint) - SUM_W'(measurement);
        err_sum  = err + SUM_W'(prev_error_reg);
        err_diff = err - SUM_W'(prev_error_reg);

        q_data.clear    = (cmd_t'(cmd) == CMD_CLEAR);
        q_data.err      = clamp_opd(err);
        q_data.err_sum  = clamp_opd(err_sum);
        q_data.err_diff = clamp_opd(err_diff);

        prev_error_next = prev_error_reg;
        if (q_push) begin
            if (cmd_t'(cmd) == CMD_CLEAR) begin
                prev_error_next = '0;
            end else if (cfg.mode != MODE_P) begin
                prev_error_next = err[ERR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_error_reg <= '0;
        end else begin
            prev_error_reg <= prev_error_next;
        end
    end

endmodule

// ===== rtl/core/dpid_queue.sv =====
// Short FIFO between the front end and the arithmetic back end.
module dpid_queue
    import dpid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    input  logic  pop,
    output item_t rdata,
    output logic  full,
    output logic  empty
);

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/dpid_back.sv =====
// Back end: multiply, integral update and output sum with saturation, three stages.
module dpid_back
    import dpid_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic                        q_empty,
    input  item_t                       q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] drive,
    output logic                        saturated
);

    localparam int ISUM_W = PROD_W + 1;
    localparam int ICMP_W = ISUM_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int OCMP_W = ((ACC_W > OUT_WIDTH) ? ACC_W : OUT_WIDTH) + 1;

    localparam logic signed [ICMP_W-1:0] INT_HI =
        (ICMP_W'(1) <<< (INTEG_W - 1)) - ICMP_W'(1);
    localparam logic signed [ICMP_W-1:0] INT_LO = -INT_HI - ICMP_W'(1);
    localparam logic signed [OCMP_W-1:0] OUT_HI =
        (OCMP_W'(1) <<< (OUT_WIDTH - 1)) - OCMP_W'(1);
    localparam logic signed [OCMP_W-1:0] OUT_LO = -OUT_HI - OCMP_W'(1);

    logic                         adv;
    logic                         use_i;
    logic                         use_d;

    // stage A: products
    logic                         a_valid_reg;
    logic                         a_clear_reg;
    logic signed [PROD_W-1:0]     p_prod_reg;
    logic signed [PROD_W-1:0]     i_prod_reg;
    logic signed [PROD_W-1:0]     d_prod_reg;
    logic signed [PROD_W-1:0]     p_prod_next;
    logic signed [PROD_W-1:0]     i_prod_next;
    logic signed [PROD_W-1:0]     d_prod_next;

    // stage B: integral
    logic                         b_valid_reg;
    logic                         b_clear_reg;
    logic                         b_isat_reg;
    logic signed [PROD_W-1:0]     b_up_reg;
    logic signed [PROD_W-1:0]     b_ud_reg;
    logic signed [INTEG_W-1:0]    b_ui_reg;
    logic signed [INTEG_W-1:0]    integ_reg;
    logic signed [INTEG_W-1:0]    integ_next;
    logic signed [ICMP_W-1:0]     isum;
    logic signed [INTEG_W-1:0]    isat_val;
    logic                         isat_flag;

    // stage C: output register
    logic                         out_valid_reg;
    logic signed [OUT_WIDTH-1:0]  drive_reg;
    logic signed [OUT_WIDTH-1:0]  drive_next;
    logic                         sat_reg;
    logic                         sat_next;
    logic signed [OCMP_W-1:0]     acc;

    assign use_i     = use_integral(cfg.mode);
    assign use_d     = use_derivative(cfg.mode);
    assign adv       = !out_valid_reg || !out_stall;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

    // products stay signed: unused terms are zeroed outside the multiply
    always_comb
    begin
        p_prod_next = q_data.err * cfg.gain_p;
        i_prod_next = '0;
        d_prod_next = '0;
        if (use_i) begin
            i_prod_next = q_data.err_sum * cfg.gain_i_half;
        end
        if (use_d) begin
            d_prod_next = q_data.err_diff * cfg.gain_d;
        end
    end

    always_comb
    begin
        isum      = ICMP_W'(integ_reg) + ICMP_W'(i_prod_reg);
        isat_flag = 1'b0;
        if (isum > INT_HI) begin
            isat_val  = INT_HI[INTEG_W-1:0];
            isat_flag = 1'b1;
        end else if (isum < INT_LO) begin
            isat_val  = INT_LO[INTEG_W-1:0];
            isat_flag = 1'b1;
        end else begin
            isat_val = isum[INTEG_W-1:0];
        end

        integ_next = integ_reg;
        if (adv && a_valid_reg) begin
            if (a_clear_reg) begin
                integ_next = '0;
            end else if (use_i) begin
                integ_next = isat_val;
            end
        end
    end

    always_comb
    begin
        acc = OCMP_W'(b_up_reg) + OCMP_W'(b_ud_reg) + OCMP_W'(b_ui_reg);
        sat_next = b_isat_reg;
        if (acc > OUT_HI) begin
            drive_next = OUT_HI[OUT_WIDTH-1:0];
            sat_next   = 1'b1;
        end else if (acc < OUT_LO) begin
            drive_next = OUT_LO[OUT_WIDTH-1:0];
            sat_next   = 1'b1;
        end else begin
            drive_next = acc[OUT_WIDTH-1:0];
        end
        if (b_clear_reg) begin
            drive_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end else begin
            integ_reg <= integ_next;
            if (adv) begin
                a_valid_reg   <= q_pop;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            a_clear_reg <= q_data.clear;
            p_prod_reg  <= p_prod_next;
            i_prod_reg  <= i_prod_next;
            d_prod_reg  <= d_prod_next;

            b_clear_reg <= a_clear_reg;
            b_up_reg    <= p_prod_reg;
            b_ud_reg    <= d_prod_reg;
            b_ui_reg    <= (use_i && !a_clear_reg) ? isat_val : '0;
            b_isat_reg  <= use_i && !a_clear_reg && isat_flag;

            drive_reg   <= drive_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

// ===== rtl/core/discrete_pid_controller_unit.sv =====
// Top level of the discrete PID controller: config registers, front, queue and back.
//
// Usage
//   Input channel (in_valid / in_stall): one word per control step carrying cmd,
//   measurement and setpoint. cmd = step runs the controller, cmd = clear zeroes
//   the previous error and the integral and yields drive 0, saturated 0.
//   Output channel (out_valid / out_stall): one word per input word, in order,
//   with drive (signed Q16.16) and the saturated flag.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 mode,
//   1 gain_p, 2 gain_i_half, 3 gain_d. cfg_ready is always high; write only
//   while no word is in flight.
// Timing
//   From input acceptance to out_valid a word passes the 4-entry queue, the
//   multiplier stage, the integral update and the output sum and saturation
//   stage, each registered. Throughput is one word per cycle while the output
//   is not stalled; the integral add-and-clamp in the middle stage closes the
//   state loop within that stage.
// Reset and backpressure
//   rst_n clears the config registers, the stored error and integral, and all
//   valid flags. A stall on the output freezes the back pipeline; the queue
//   then absorbs up to 4 more words before in_stall rises.
module discrete_pid_controller_unit
    import dpid_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [DATA_WIDTH-1:0] measurement,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [OUT_WIDTH-1:0]  drive,
    output logic                         saturated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    item_t q_wdata;
    item_t q_rdata;

    assign cfg_ready = 1'b1;

    // register file: one word per write, always accepted
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:        cfg_next.mode        = mode_t'(cfg_data[1:0]);
                REG_GAIN_P:      cfg_next.gain_p      = cfg_data[GAIN_W-1:0];
                REG_GAIN_I_HALF: cfg_next.gain_i_half = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d      = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: error, error sum and difference, previous-error tracking
    dpid_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .measurement (measurement),
        .setpoint    (setpoint),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    dpid_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: products, integral state, output saturation and output register
    dpid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .saturated (saturated)
    );

endmodule

// ===== rtl/core/dpid_checker.sv =====
// Port-level checks for the discrete PID controller, bound to the top level.
module dpid_checker
    import dpid_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [OUT_WIDTH-1:0] drive,
    input logic                        saturated,
    input logic                        cfg_ready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(saturated))
        else $error("stalled result changed");

    // a result only leaves when taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    // reset empties the output register once it has been held over an edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n && $past(!rst_n) |-> !out_valid)
        else $error("out_valid high during reset");

    // register writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind discrete_pid_controller_unit dpid_checker u_dpid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .saturated (saturated),
    .cfg_ready (cfg_ready)
);

// ===== tb/tb_discrete_pid_controller_unit.sv =====
// Self-checking testbench for the discrete PID controller unit.
module tb_discrete_pid_controller_unit
    import dpid_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CLK_HALF     = 2;
    localparam int  RST_CYCLES   = 7;
    localparam int  PIPE_SLACK   = 8;       // well past the pipeline latency
    localparam int  HOLD_CYCLES  = 300;     // long output hold-off
    localparam int  RAND_PHASES  = 12;
    localparam int  WORDS_PER_PH = 155;
    localparam int  MAX_MISMATCH = 10;
    localparam longint CYCLE_LIMIT = 400000;

    // One input word as the sender presents it.
    typedef struct {
        cmd_t                         cmd;
        logic signed [DATA_WIDTH-1:0] meas;
        logic signed [DATA_WIDTH-1:0] sp;
    } step_word_t;

    // One expected output word.
    typedef struct {
        logic signed [OUT_WIDTH-1:0] drive;
        logic                        sat;
    } ctrl_out_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    cmd_t                         cmd;
    logic signed [DATA_WIDTH-1:0] measurement;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [OUT_WIDTH-1:0]  drive;
    logic                         saturated;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    discrete_pid_controller_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .measurement (measurement),
        .setpoint    (setpoint),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Words waiting for the driver, and control outputs still owed by the block.
    step_word_t pending_words[$];
    ctrl_out_t  owed_outputs[$];

    // Shadow copy of the controller: config registers and stored state.
    mode_t                    pid_mode;
    logic signed [GAIN_W-1:0] pid_kp;
    logic signed [GAIN_W-1:0] pid_ki_half;
    logic signed [GAIN_W-1:0] pid_kd;
    longint                   pid_prev_err;
    longint                   pid_integ;

    int     n_mismatch;
    int     n_steps;
    int     n_clears;
    int     n_sat;
    int     n_in_stall;
    longint n_cycles;
    logic   in_taken;

    // Hold-off handshake between the sequence and the output stall process.
    int hold_req;
    int hold_ack;
    int hold_cnt;
    int stall_win;
    int stall_pct;

    // Sender burst shaping.
    int burst_left;
    int gap_left;

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    //------------------------------------------------------------------
    // Controller prediction
    //------------------------------------------------------------------

    // Multiplier operands are limited to +-2^30; never bites at 16-bit data
    // but kept so the shadow stays exact for any sample width.
    function automatic longint limit_opd(longint x);
        longint lim;
        lim = longint'(1) <<< 30;
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Clamp to a signed width and flag the clamp.
    function automatic longint clamp_signed(longint x, int w, inout logic flag);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (x < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return x;
    endfunction

    // Advance the shadow controller by one word and return its output.
    function automatic ctrl_out_t pid_update(step_word_t w);
        ctrl_out_t r;
        longint    err;
        longint    p_term;
        longint    i_term;
        longint    d_term;
        longint    total;
        logic      sat;
        logic      has_i;
        logic      has_d;
        sat    = 1'b0;
        i_term = 0;
        d_term = 0;
        if (w.cmd == CMD_CLEAR)
        begin
            pid_prev_err = 0;
            pid_integ    = 0;
            r.drive      = '0;
            r.sat        = 1'b0;
            return r;
        end
        has_i  = (pid_mode == MODE_PID) || (pid_mode == MODE_PI);
        has_d  = (pid_mode == MODE_PID) || (pid_mode == MODE_PD);
        err    = longint'(w.sp) - longint'(w.meas);
        p_term = longint'(pid_kp) * limit_opd(err);
        if (has_i)
            i_term = clamp_signed(pid_integ
                         + longint'(pid_ki_half) * limit_opd(pid_prev_err + err),
                         INTEG_W, sat);
        if (has_d)
            d_term = longint'(pid_kd) * limit_opd(err - pid_prev_err);
        total = clamp_signed(p_term + i_term + d_term, OUT_WIDTH, sat);
        if (has_i)
            pid_integ = i_term;
        if (pid_mode != MODE_P)
            pid_prev_err = err;
        r.drive = OUT_WIDTH'(total);
        r.sat   = sat;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Input driver: words leave the queue in random bursts, fields change
    // on the falling edge and stay put while the block stalls.
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        step_word_t w;
        logic       next_valid;
        if (rst_n && (!in_valid || in_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_words.size() > 0)
            begin
                w           = pending_words.pop_front();
                cmd         <= w.cmd;
                measurement <= w.meas;
                setpoint    <= w.sp;
                next_valid  = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // about a third of bursts are followed by a gap
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
            in_valid <= next_valid;
        end
    end

    //------------------------------------------------------------------
    // Output stall: windows of random stall density, plus the long
    // hold-off when the sequence asks for one.
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
            begin
                hold_cnt = 0;
                hold_ack = hold_req;
            end
        end
        else
        begin
            if (stall_win <= 0)
            begin
                stall_win = $urandom_range(16, 96);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;     // free-running stretches
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_win--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    //------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge.  Config writes and
    // accepted input words advance the shadow; accepted outputs are checked
    // in order against what the shadow owes.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        ctrl_out_t  want;
        step_word_t w;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && in_stall)
                n_in_stall++;

            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:        pid_mode    = mode_t'(cfg_data[1:0]);
                    REG_GAIN_P:      pid_kp      = cfg_data;
                    REG_GAIN_I_HALF: pid_ki_half = cfg_data;
                    REG_GAIN_D:      pid_kd      = cfg_data;
                    default:         ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                w.cmd  = cmd;
                w.meas = measurement;
                w.sp   = setpoint;
                if (cmd == CMD_CLEAR)
                    n_clears++;
                else
                    n_steps++;
                owed_outputs.push_back(pid_update(w));
            end

            if (out_valid && !out_stall)
            begin
                if (owed_outputs.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_MISMATCH)
                        $display("%0t: unexpected output word drive=%0d saturated=%0b",
                                 $realtime, drive, saturated);
                end
                else
                begin
                    want = owed_outputs.pop_front();
                    if (saturated)
                        n_sat++;
                    if (drive !== want.drive || saturated !== want.sat)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_MISMATCH)
                            $display("%0t: mismatch drive exp=%0d got=%0d, saturated exp=%0b got=%0b",
                                     $realtime, want.drive, drive, want.sat, saturated);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog
    //------------------------------------------------------------------
    initial
    begin
        n_cycles = 0;
        forever
        begin
            @(posedge clk);
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d output words still owed",
                         n_cycles, owed_outputs.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Sequence helpers
    //------------------------------------------------------------------
    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Only called while the block holds no word.
    task automatic set_config(mode_t m, logic [31:0] kp, logic [31:0] ki,
                              logic [31:0] kd);
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I_HALF, ki);
        write_reg(REG_GAIN_D, kd);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_word(cmd_t c, int meas, int sp);
        step_word_t w;
        w.cmd  = c;
        w.meas = DATA_WIDTH'(meas);
        w.sp   = DATA_WIDTH'(sp);
        pending_words.push_back(w);
    endtask

    // Wait until every word has gone out and come back, then let the pipe settle.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() > 0 || in_valid || owed_outputs.size() > 0);
        repeat (PIPE_SLACK) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return 32'($signed($urandom_range(0, 32767)) - 16384);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // About half the step samples track near the setpoint, the rest are random or
    // extreme, with an occasional clear.
    task automatic push_random(int n);
        int sp;
        int meas;
        repeat (n)
        begin
            sp   = $signed($urandom_range(0, 65535)) - 32768;
            meas = $signed($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 19) == 0)
            begin
                push_word(CMD_CLEAR, meas, sp);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        meas = sp + $signed($urandom_range(0, 400)) - 200;
                        if (meas > 32767)
                            meas = 32767;
                        if (meas < -32768)
                            meas = -32768;
                    end
                    2:       ;
                    default:
                    begin
                        sp   = pick_extreme();
                        meas = pick_extreme();
                    end
                endcase
                push_word(CMD_STEP, meas, sp);
            end
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        mode_t m;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_STEP;
        measurement  = '0;
        setpoint     = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pid_mode     = MODE_PID;
        pid_kp       = '0;
        pid_ki_half  = '0;
        pid_kd       = '0;
        pid_prev_err = 0;
        pid_integ    = 0;
        n_mismatch   = 0;
        n_steps      = 0;
        n_clears     = 0;
        n_sat        = 0;
        n_in_stall   = 0;
        hold_req     = 0;
        hold_ack     = 0;
        hold_cnt     = 0;
        stall_win    = 0;
        stall_pct    = 0;
        burst_left   = 1;
        gap_left     = 0;

        repeat (RST_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Reset config: all gains zero, so drive must be zero.
        push_word(CMD_STEP, 100, -100);
        push_word(CMD_STEP, -32768, 32767);
        drain();

        // Moderate gains (1.0, 0.5, 2.0): largest errors both ways, then clear.
        set_config(MODE_PID, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
        push_word(CMD_STEP, -32768, 32767);
        push_word(CMD_STEP, 32767, -32768);
        push_word(CMD_STEP, 32767, 32767);
        push_word(CMD_STEP, -32768, -32768);
        push_word(CMD_CLEAR, 1234, -4321);
        push_word(CMD_STEP, -1, 1);
        drain();

        // Largest positive gains: integral and output clamp high, then low.
        set_config(MODE_PID, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_word(CMD_STEP, -32768, 32767);
        push_word(CMD_STEP, -32768, 32767);
        push_word(CMD_STEP, 32767, -32768);
        drain();

        // Most negative gains.
        set_config(MODE_PID, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_word(CMD_STEP, -32768, 32767);
        push_word(CMD_STEP, 32767, -32768);
        push_word(CMD_STEP, 32767, -32768);
        drain();

        // Each reduced mode: P keeps no state, PI skips the derivative,
        // PD leaves the integral alone.
        set_config(MODE_P, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
        push_word(CMD_STEP, 10, 20);
        push_word(CMD_STEP, 10, 20);
        drain();
        set_config(MODE_PI, 32'h0001_0000, 32'h0000_4000, 32'h0004_0000);
        push_word(CMD_STEP, -50, 50);
        push_word(CMD_STEP, 50, -50);
        drain();
        set_config(MODE_PD, 32'h0001_0000, 32'h7fff_ffff, 32'h0002_0000);
        push_word(CMD_STEP, 0, 300);
        push_word(CMD_STEP, 0, -300);
        push_word(CMD_STEP, 32767, -32768);
        drain();

        // Random phases, each under a fresh configuration.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            m = mode_t'($urandom_range(0, 3));
            set_config(m, pick_gain(), pick_gain(), pick_gain());
            if (ph == 1)
            begin
                // Long output hold-off while the sender keeps offering words:
                // the queue fills and the input side has to stall.
                @(posedge clk);
                hold_req++;
            end
            push_random(WORDS_PER_PH);
            drain();
        end

        $display("covered %0d step words and %0d clears over %0d random configurations",
                 n_steps, n_clears, RAND_PHASES);
        $display("saturated outputs: %0d, input stall cycles: %0d, mismatches: %0d",
                 n_sat, n_in_stall, n_mismatch);
        if (n_mismatch == 0 && owed_outputs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dpid_pkg.sv
rtl/core/dpid_front.sv
rtl/core/dpid_queue.sv
rtl/core/dpid_back.sv
rtl/core/discrete_pid_controller_unit.sv
rtl/core/dpid_checker.sv
tb/tb_discrete_pid_controller_unit.sv
